>>> sv/serial_packet_framer_with_checksum_unit_defines.svh
// Assertion macros shared by the checking code of the packet framer.
`ifndef SERIAL_PACKET_FRAMER_WITH_CHECKSUM_UNIT_DEFINES_SVH
`define SERIAL_PACKET_FRAMER_WITH_CHECKSUM_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SPFC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("packet framer check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SPFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("packet framer check failed");

`endif

>>> sv/spfc_pkg.sv
// Types and constants shared by the packet framer modules.
package spfc_pkg;

	localparam logic [15:0] HEADER_WORD = 16'h5454;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_INFO   = 2'd1;
	localparam logic [1:0] KIND_DATA   = 2'd2;
	localparam logic [1:0] KIND_CHECK  = 2'd3;

	typedef struct packed {
		logic        first;
		logic [15:0] info;
		logic        has_data;
		logic [15:0] data;
		logic        last;
		logic [15:0] chk;
	} spfc_entry_t;

	typedef struct packed {
		logic        valid;
		spfc_entry_t entry;
	} spfc_head_t;

endpackage

>>> sv/spfc_front.sv
// Front end: tracks packet position and running sum, and classifies each accepted word.
module spfc_front
	import spfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [15:0] data_word,
	input  logic [5:0]  word_count,
	input  logic        read_request,
	input  logic [1:0]  words_per_value,
	input  logic        type_select,
	input  logic [5:0]  target_index,
	output spfc_entry_t entry
);

	logic        in_packet_q;
	logic [5:0]  words_left_q;
	logic [15:0] sum_q;

	logic        first;
	logic [15:0] info;
	logic        has_data;
	logic [15:0] sum_base;
	logic [15:0] new_sum;
	logic [5:0]  left_new;
	logic        last;

	always_comb begin
		first    = !in_packet_q;
		info     = {word_count, target_index, type_select, words_per_value, read_request};
		has_data = in_packet_q || (word_count != 6'd0);
		sum_base = first ? info : sum_q;
		new_sum  = has_data ? (sum_base + data_word) : sum_base;
		left_new = first ? (word_count - 6'd1) : (words_left_q - 6'd1);
		last     = !has_data || (left_new == 6'd0);

		entry.first    = first;
		entry.info     = info;
		entry.has_data = has_data;
		entry.data     = data_word;
		entry.last     = last;
		entry.chk      = ~new_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q  <= 1'b0;
			words_left_q <= 6'd0;
			sum_q        <= 16'd0;
		end else if (accept) begin
			in_packet_q  <= has_data && !last;
			words_left_q <= last ? 6'd0 : left_new;
			sum_q        <= last ? 16'd0 : new_sum;
		end
	end

endmodule

>>> sv/spfc_queue.sv
// Short queue of classified words between the front end and the output sequencer.
module spfc_queue
	import spfc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        enq,
	input  spfc_entry_t enq_entry,
	input  logic        deq,
	output logic        full,
	output spfc_head_t  head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	spfc_entry_t             store_q [DEPTH];
	logic        [PTR_W-1:0] wr_ptr_q;
	logic        [PTR_W-1:0] rd_ptr_q;
	logic        [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			store_q[wr_ptr_q] <= enq_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (enq && !deq) begin
				count_q <= count_q + CNT_W'(1);
			end else if (deq && !enq) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> sv/spfc_back.sv
// Back end: expands each classified word into link words and holds the output register.
module spfc_back
	import spfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  spfc_head_t  head,
	output logic        deq,
	input  logic        pop,
	output logic        empty,
	output logic [15:0] out_word,
	output logic [1:0]  word_kind,
	output logic        end_of_packet
);

	typedef enum logic [3:0] {
		PH_HDR  = 4'b0001,
		PH_INFO = 4'b0010,
		PH_DATA = 4'b0100,
		PH_CHK  = 4'b1000
	} phase_t;

	phase_t      phase_q;
	logic        mid_q;
	logic        out_valid_q;
	logic [15:0] word_q;
	logic [1:0]  kind_q;
	logic        eop_q;

	phase_t      cur;
	phase_t      nxt;
	logic        fin;
	logic        load;
	logic [15:0] word_d;
	logic [1:0]  kind_d;
	logic        eop_d;

	always_comb begin
		if (mid_q) begin
			cur = phase_q;
		end else begin
			cur = head.entry.first ? PH_HDR : PH_DATA;
		end
		nxt    = PH_HDR;
		fin    = 1'b0;
		eop_d  = 1'b0;
		word_d = HEADER_WORD;
		kind_d = KIND_HEADER;
		case (cur)
			PH_HDR: begin
				nxt = PH_INFO;
			end
			PH_INFO: begin
				word_d = head.entry.info;
				kind_d = KIND_INFO;
				nxt    = head.entry.has_data ? PH_DATA : PH_CHK;
			end
			PH_DATA: begin
				word_d = head.entry.data;
				kind_d = KIND_DATA;
				nxt    = PH_CHK;
				fin    = !head.entry.last;
			end
			PH_CHK: begin
				word_d = head.entry.chk;
				kind_d = KIND_CHECK;
				eop_d  = 1'b1;
				fin    = 1'b1;
			end
			default: begin
				fin = 1'b1;
			end
		endcase
		load = head.valid && (!out_valid_q || pop);
		deq  = load && fin;
	end

	assign empty         = !out_valid_q;
	assign out_word      = word_q;
	assign word_kind     = kind_q;
	assign end_of_packet = eop_q;

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= word_d;
			kind_q <= kind_d;
			eop_q  <= eop_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			mid_q       <= 1'b0;
			phase_q     <= PH_HDR;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				mid_q       <= !fin;
				phase_q     <= nxt;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/serial_packet_framer_with_checksum_unit.sv
// Top level of the serial packet framer with checksum.
// Each accepted data word yields one link word, except that the first word of a packet
// also yields the header word 0x5454 and the info word before it, and the last counted
// word also yields the closing checksum word; a first word with a zero count yields the
// header, info and checksum words but no data word. The output register produces one
// link word per cycle while pop is held, so a steady stream of data words moves at one
// word per cycle; the three or four words at the ends of a packet stall the input only
// once the QUEUE_DEPTH-entry queue between the classifying front end and the output
// sequencer has filled. A word reaches the ports via the queue and the output register.
module serial_packet_framer_with_checksum_unit
	import spfc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] data_word,
	input  logic [5:0]  word_count,
	input  logic        read_request,
	input  logic [1:0]  words_per_value,
	input  logic        type_select,
	input  logic [5:0]  target_index,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] out_word,
	output logic [1:0]  word_kind,
	output logic        end_of_packet
);

	logic        accept;
	logic        deq;
	spfc_entry_t entry;
	spfc_head_t  head;

	assign accept = push && !full;

	spfc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.data_word       (data_word),
		.word_count      (word_count),
		.read_request    (read_request),
		.words_per_value (words_per_value),
		.type_select     (type_select),
		.target_index    (target_index),
		.entry           (entry)
	);

	spfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.enq       (accept),
		.enq_entry (entry),
		.deq       (deq),
		.full      (full),
		.head      (head)
	);

	spfc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.deq           (deq),
		.pop           (pop),
		.empty         (empty),
		.out_word      (out_word),
		.word_kind     (word_kind),
		.end_of_packet (end_of_packet)
	);

endmodule

>>> sv/spfc_checker.sv
// Port-level checker for the packet framer and its bind to the top level.
`include "serial_packet_framer_with_checksum_unit_defines.svh"

module spfc_checker
	import spfc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [15:0] out_word,
	input logic [1:0]  word_kind,
	input logic        end_of_packet
);

	logic [1:0] prev_kind_q;
	logic       xfer;

	assign xfer = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_kind_q <= KIND_CHECK;
		end else if (xfer) begin
			prev_kind_q <= word_kind;
		end
	end

	`SPFC_ASSERT_NEXT(a_out_hold, clk, arst_n, !empty && !pop, !empty && $stable(out_word) && $stable(word_kind))
	`SPFC_ASSERT_SAME(a_eop_on_check, clk, arst_n, !empty, end_of_packet == (word_kind == KIND_CHECK))
	`SPFC_ASSERT_SAME(a_header_value, clk, arst_n, !empty && word_kind == KIND_HEADER, out_word == HEADER_WORD)
	`SPFC_ASSERT_SAME(a_info_after_header, clk, arst_n, xfer && prev_kind_q == KIND_HEADER, word_kind == KIND_INFO)
	`SPFC_ASSERT_SAME(a_header_after_check, clk, arst_n, xfer && prev_kind_q == KIND_CHECK, word_kind == KIND_HEADER)

endmodule

bind serial_packet_framer_with_checksum_unit spfc_checker u_spfc_checker (.*);

>>> sim/tb_serial_packet_framer_with_checksum_unit.sv
// Self-checking testbench for the serial packet framer with checksum.
module tb_serial_packet_framer_with_checksum_unit;
	import spfc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] data;
		logic [5:0]  cnt;
		logic        rd;
		logic [1:0]  wpv;
		logic        typ;
		logic [5:0]  idx;
	} frame_in_t;

	typedef struct packed {
		logic [15:0] word;
		logic [1:0]  kind;
		logic        eop;
	} link_word_t;

	typedef struct packed {
		frame_in_t             in;
		logic [2:0]            n_typed;
		link_word_t [0:3]      typed;
	} frame_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [15:0] data_word = '0;
	logic [5:0]  word_count = '0;
	logic        read_request = 1'b0;
	logic [1:0]  words_per_value = '0;
	logic        type_select = 1'b0;
	logic [5:0]  target_index = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [15:0] out_word;
	logic [1:0]  word_kind;
	logic        end_of_packet;

	link_word_t  link_expect[$];
	frame_row_t  frame_rows[$];
	int          n_fail = 0;
	bit          calm = 1'b0;

	bit          in_pkt = 1'b0;
	logic [5:0]  words_left = '0;
	logic [15:0] run_sum = '0;

	serial_packet_framer_with_checksum_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_word(data_word),
		.word_count(word_count),
		.read_request(read_request),
		.words_per_value(words_per_value),
		.type_select(type_select),
		.target_index(target_index),
		.empty(empty),
		.pop(pop),
		.out_word(out_word),
		.word_kind(word_kind),
		.end_of_packet(end_of_packet)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#1ms;
		$display("TEST FAILED");
		$finish;
	end

	function automatic frame_in_t fi(logic [15:0] data, logic [5:0] cnt, logic rd,
			logic [1:0] wpv, logic typ, logic [5:0] idx);
		return '{data: data, cnt: cnt, rd: rd, wpv: wpv, typ: typ, idx: idx};
	endfunction

	function automatic link_word_t lw(logic [15:0] word, logic [1:0] kind, logic eop);
		return '{word: word, kind: kind, eop: eop};
	endfunction

	function automatic frame_in_t random_item();
		return fi(16'($urandom), 6'($urandom), 1'($urandom), 2'($urandom), 1'($urandom),
			6'($urandom));
	endfunction

	// Advances the framer state by one data word and, if asked, queues the link words due.
	task automatic frame_item(input frame_in_t v, input bit record);
		link_word_t  words[$];
		logic [15:0] info;
		bit          closed;
		closed = 1'b0;
		if (!in_pkt) begin
			info = {v.cnt, v.idx, v.typ, v.wpv, v.rd};
			words.push_back(lw(HEADER_WORD, KIND_HEADER, 1'b0));
			words.push_back(lw(info, KIND_INFO, 1'b0));
			run_sum = info;
			if (v.cnt == 6'd0) begin
				words.push_back(lw(~run_sum, KIND_CHECK, 1'b1));
				run_sum = '0;
				words_left = '0;
				closed = 1'b1;
			end else begin
				words.push_back(lw(v.data, KIND_DATA, 1'b0));
				run_sum = run_sum + v.data;
				words_left = v.cnt - 6'd1;
				in_pkt = 1'b1;
			end
		end else begin
			words.push_back(lw(v.data, KIND_DATA, 1'b0));
			run_sum = run_sum + v.data;
			words_left = words_left - 6'd1;
		end
		if (!closed && words_left == 6'd0) begin
			words.push_back(lw(~run_sum, KIND_CHECK, 1'b1));
			run_sum = '0;
			in_pkt = 1'b0;
		end
		if (record) begin
			foreach (words[i]) link_expect.push_back(words[i]);
		end
	endtask

	task automatic send_word(input frame_in_t v);
		bit taken;
		if (!calm && $urandom_range(0, 99) < 12) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		data_word <= v.data;
		word_count <= v.cnt;
		read_request <= v.rd;
		words_per_value <= v.wpv;
		type_select <= v.typ;
		target_index <= v.idx;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end
	endtask

	task automatic drain_results();
		push <= 1'b0;
		while (link_expect.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		pop <= calm ? 1'b1 : ($urandom_range(0, 99) >= 12);
	end

	always @(negedge clk) begin
		link_word_t exp_w;
		if (arst_n && pop && !empty) begin
			if (link_expect.size() == 0) begin
				$error("unexpected link word %h kind %0d", out_word, word_kind);
				n_fail++;
			end else begin
				exp_w = link_expect.pop_front();
				if (out_word !== exp_w.word) begin
					$error("out_word expected %h actual %h", exp_w.word, out_word);
					n_fail++;
				end
				if (word_kind !== exp_w.kind) begin
					$error("word_kind expected %0d actual %0d", exp_w.kind, word_kind);
					n_fail++;
				end
				if (end_of_packet !== exp_w.eop) begin
					$error("end_of_packet expected %0d actual %0d", exp_w.eop,
						end_of_packet);
					n_fail++;
				end
			end
		end
	end

	initial begin
		frame_in_t v;
		int        n_rand;
		int        cnt;
		bit        fresh;

		frame_rows.push_back('{in: fi(16'hABCD, 6'd0, 1'b0, 2'd0, 1'b0, 6'd0), n_typed: 3'd3,
			typed: {lw(HEADER_WORD, KIND_HEADER, 1'b0), lw(16'h0000, KIND_INFO, 1'b0),
				lw(16'hFFFF, KIND_CHECK, 1'b1), lw(16'h0000, KIND_HEADER, 1'b0)}});
		frame_rows.push_back('{in: fi(16'hFFFF, 6'd1, 1'b1, 2'd3, 1'b1, 6'd63), n_typed: 3'd4,
			typed: {lw(HEADER_WORD, KIND_HEADER, 1'b0), lw(16'h07FF, KIND_INFO, 1'b0),
				lw(16'hFFFF, KIND_DATA, 1'b0), lw(16'hF801, KIND_CHECK, 1'b1)}});
		frame_rows.push_back('{in: fi(16'h0000, 6'd0, 1'b1, 2'd3, 1'b1, 6'd63), n_typed: 3'd3,
			typed: {lw(HEADER_WORD, KIND_HEADER, 1'b0), lw(16'h03FF, KIND_INFO, 1'b0),
				lw(16'hFC00, KIND_CHECK, 1'b1), lw(16'h0000, KIND_HEADER, 1'b0)}});
		frame_rows.push_back('{in: fi(16'h1234, 6'd3, 1'b1, 2'd2, 1'b0, 6'd21), default: '0});
		frame_rows.push_back('{in: fi(16'h8000, 6'd0, 1'b0, 2'd1, 1'b1, 6'd5), default: '0});
		frame_rows.push_back('{in: fi(16'hFFFF, 6'd63, 1'b1, 2'd3, 1'b1, 6'd63), default: '0});
		frame_rows.push_back('{in: fi(16'hFFFF, 6'd2, 1'b0, 2'd1, 1'b0, 6'd42), default: '0});
		frame_rows.push_back('{in: fi(16'hFFFF, 6'd1, 1'b1, 2'd0, 1'b1, 6'd0), default: '0});
		frame_rows.push_back('{in: fi(16'h0000, 6'd1, 1'b0, 2'd0, 1'b0, 6'd0), default: '0});
		frame_rows.push_back('{in: fi(16'h5454, 6'd1, 1'b0, 2'd3, 1'b0, 6'd1), default: '0});
		frame_rows.push_back('{in: fi(16'h0001, 6'd4, 1'b0, 2'd2, 1'b1, 6'd32), default: '0});
		frame_rows.push_back('{in: fi(16'h0002, 6'd63, 1'b1, 2'd1, 1'b0, 6'd31), default: '0});
		frame_rows.push_back('{in: fi(16'h0004, 6'd0, 1'b0, 2'd0, 1'b0, 6'd0), default: '0});
		frame_rows.push_back('{in: fi(16'h8000, 6'd1, 1'b1, 2'd3, 1'b1, 6'd63), default: '0});
		frame_rows.push_back('{in: fi(16'h7FFF, 6'd32, 1'b0, 2'd1, 1'b0, 6'd16), default: '0});
		frame_rows.push_back('{in: fi(16'hAAAA, 6'd5, 1'b1, 2'd2, 1'b1, 6'd10), default: '0});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (frame_rows[r]) begin
			send_word(frame_rows[r].in);
			frame_item(frame_rows[r].in, frame_rows[r].n_typed == 3'd0);
			for (int k = 0; k < frame_rows[r].n_typed; k++)
				link_expect.push_back(frame_rows[r].typed[k]);
		end
		// The 32-word packet opened above is finished by the first random words.
		while (in_pkt) begin
			v = random_item();
			send_word(v);
			frame_item(v, 1'b1);
		end
		drain_results();

		n_rand = 0;
		while (n_rand < 120) begin
			calm = (n_rand >= 40 && n_rand < 80);
			cnt = $urandom_range(0, 99);
			if (cnt < 10)
				cnt = 0;
			else if (cnt < 13)
				cnt = 63;
			else if (cnt < 25)
				cnt = $urandom_range(9, 62);
			else
				cnt = $urandom_range(1, 8);
			fresh = 1'b1;
			do begin
				v = random_item();
				if (fresh)
					v.cnt = 6'(cnt);
				send_word(v);
				frame_item(v, 1'b1);
				n_rand++;
				fresh = 1'b0;
			end while (in_pkt);
		end
		calm = 1'b0;
		drain_results();
		repeat (20) @(posedge clk);

		if (n_fail == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
